// File: sv/dspm_pkg.sv
// ----------------------------------------------------------------------------
// Dot-star pattern matcher package
// Shared constants and register index codes for the matcher block.
// ----------------------------------------------------------------------------
package dspm_pkg;

   // Largest pattern held in the configuration registers
   localparam int PatternMaxDefault = 16;

   // Configuration port geometry
   localparam int CsrIndexW = 2;
   localparam int CsrDataW  = 64;
   localparam int PatLengthW = 5;

   // Register index codes
   localparam logic [CsrIndexW-1:0] CsrPatFirst  = 2'd0;
   localparam logic [CsrIndexW-1:0] CsrPatSecond = 2'd1;
   localparam logic [CsrIndexW-1:0] CsrPatLength = 2'd2;

   // Pattern metacharacters
   localparam logic [7:0] DotByte  = 8'h2E;
   localparam logic [7:0] StarByte = 8'h2A;

endpackage

// File: sv/dot_star_pattern_matcher_top.sv
// ----------------------------------------------------------------------------
// Dot-star pattern matcher top level
// Path: a request beat passes the input register, then the result register.
// Throughput: one text byte per cycle unless the response side stalls; the
// live set update is a single combinational step between the two registers.
// Reset: pattern registers clear to an empty pattern, both stages empty,
// the live set returns to the start set.
// ----------------------------------------------------------------------------
module dot_star_pattern_matcher_top #(
   parameter int PATTERN_MAX = dspm_pkg::PatternMaxDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_text_byte,
   input  logic                           req_byte_present,
   input  logic                           req_end_of_text,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_whole_match,
   output logic                           rsp_text_done,
   input  logic                           csr_wr_en,
   input  logic [dspm_pkg::CsrIndexW-1:0] csr_index,
   input  logic [dspm_pkg::CsrDataW-1:0]  csr_wdata
);
   import dspm_pkg::*;

   localparam int LenW = $clog2(PATTERN_MAX + 1);

   logic [PATTERN_MAX*8-1:0] pat_bytes;
   logic [LenW-1:0]          pat_len;
   logic [PATTERN_MAX-1:0]   star_mask;
   logic                     cfg_restart;

   // Pattern registers
   dspm_cfg #(
      .PATTERN_MAX(PATTERN_MAX)
   ) u_cfg (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .pat_bytes  (pat_bytes),
      .pat_len    (pat_len),
      .star_mask  (star_mask),
      .cfg_restart(cfg_restart)
   );

   // Matching datapath
   dspm_engine #(
      .PATTERN_MAX(PATTERN_MAX)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_text_byte   (req_text_byte),
      .req_byte_present(req_byte_present),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_whole_match (rsp_whole_match),
      .rsp_text_done   (rsp_text_done),
      .pat_bytes       (pat_bytes),
      .pat_len         (pat_len),
      .star_mask       (star_mask),
      .cfg_restart     (cfg_restart)
   );

endmodule

// File: sv/dspm_cfg.sv
// ----------------------------------------------------------------------------
// Dot-star matcher configuration registers
// Holds the pattern bytes and length, clamps the length and derives the
// per-position star mask used by the matching engine.
// ----------------------------------------------------------------------------
module dspm_cfg #(
   parameter int PATTERN_MAX = dspm_pkg::PatternMaxDefault,
   localparam int LenW = $clog2(PATTERN_MAX + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [dspm_pkg::CsrIndexW-1:0]    csr_index,
   input  logic [dspm_pkg::CsrDataW-1:0]     csr_wdata,
   output logic [PATTERN_MAX*8-1:0]          pat_bytes,
   output logic [LenW-1:0]                   pat_len,
   output logic [PATTERN_MAX-1:0]            star_mask,
   output logic                              cfg_restart
);
   import dspm_pkg::*;

   logic [CsrDataW-1:0]   pat_first_ff;
   logic [CsrDataW-1:0]   pat_second_ff;
   logic [PatLengthW-1:0] pat_length_ff;
   logic [2*CsrDataW-1:0] all_bytes;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_first_ff  <= '0;
         pat_second_ff <= '0;
         pat_length_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CsrPatFirst:  pat_first_ff  <= csr_wdata;
            CsrPatSecond: pat_second_ff <= csr_wdata;
            CsrPatLength: pat_length_ff <= csr_wdata[PatLengthW-1:0];
            default: ;
         endcase
      end
   end

   // Any write to a real register restarts the current text
   assign cfg_restart = csr_wr_en && ((csr_index == CsrPatFirst) ||
                                      (csr_index == CsrPatSecond) ||
                                      (csr_index == CsrPatLength));

   assign all_bytes = {pat_second_ff, pat_first_ff};

   // Length in use, clamped to the position count
   always_comb begin
      if (pat_length_ff > PatLengthW'(PATTERN_MAX)) begin
         pat_len = LenW'(PATTERN_MAX);
      end else begin
         pat_len = pat_length_ff[LenW-1:0];
      end
   end

   // Pattern bytes and star mask: position j is starred when byte j+1 is '*'
   always_comb begin
      star_mask = '0;
      for (int k = 0; k < PATTERN_MAX; k++) begin
         pat_bytes[8*k +: 8] = all_bytes[8*k +: 8];
      end
      for (int j = 0; j + 1 < PATTERN_MAX; j++) begin
         star_mask[j] = (j + 1 < int'(pat_len)) && (all_bytes[8*(j+1) +: 8] == StarByte);
      end
   end

endmodule

// File: sv/dspm_engine.sv
// ----------------------------------------------------------------------------
// Dot-star matcher engine
// Input register, live position set update and result register. One text
// byte advances the whole position set in a single combinational step.
// ----------------------------------------------------------------------------
module dspm_engine #(
   parameter int PATTERN_MAX = dspm_pkg::PatternMaxDefault,
   localparam int LenW = $clog2(PATTERN_MAX + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_text_byte,
   input  logic                     req_byte_present,
   input  logic                     req_end_of_text,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_whole_match,
   output logic                     rsp_text_done,
   input  logic [PATTERN_MAX*8-1:0] pat_bytes,
   input  logic [LenW-1:0]          pat_len,
   input  logic [PATTERN_MAX-1:0]   star_mask,
   input  logic                     cfg_restart
);
   import dspm_pkg::*;

   localparam int NPos = PATTERN_MAX + 1;

   // Input stage
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_present_ff;
   logic       in_eot_ff;

   // Live set
   logic [NPos-1:0] live_ff, live_in;
   logic            restart_ff, restart_in;

   // Result stage
   logic rsp_valid_ff;
   logic rsp_match_ff, rsp_match_in;
   logic rsp_done_ff;

   logic            advance;
   logic            consume;
   logic [NPos-1:0] start_set;
   logic [NPos-1:0] cur_set;
   logic [NPos-1:0] step_set;
   logic [NPos-1:0] new_set;

   // Forward closure over star skips: a live starred j also makes j+2 live
   function automatic logic [NPos-1:0] close_set(input logic [NPos-1:0] s,
                                                 input logic [PATTERN_MAX-1:0] st);
      logic [NPos-1:0] c;
      c = s;
      for (int j = 0; j + 2 < NPos; j++) begin
         c[j+2] = c[j+2] | (c[j] & st[j]);
      end
      return c;
   endfunction

   // Handshake: result register frees up, input stage follows
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign consume   = in_valid_ff && advance;

   // Set in effect for the next byte
   assign start_set = close_set(NPos'(1), star_mask);
   assign cur_set   = restart_ff ? start_set : live_ff;

   // One byte step: matched positions loop (starred) or move on by one
   always_comb begin
      step_set = '0;
      for (int j = 0; j < PATTERN_MAX; j++) begin
         if (cur_set[j] && (j < int'(pat_len)) &&
             ((pat_bytes[8*j +: 8] == in_byte_ff) ||
              (pat_bytes[8*j +: 8] == DotByte))) begin
            if (star_mask[j]) begin
               step_set[j] = 1'b1;
            end else begin
               step_set[j+1] = 1'b1;
            end
         end
      end
   end

   assign new_set      = in_present_ff ? close_set(step_set, star_mask) : cur_set;
   assign rsp_match_in = new_set[pat_len];

   // Live set update; end of text or a register write returns to the start set
   always_comb begin
      live_in    = live_ff;
      restart_in = restart_ff;
      if (cfg_restart) begin
         restart_in = 1'b1;
      end else if (consume) begin
         live_in    = new_set;
         restart_in = in_eot_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         restart_ff   <= 1'b1;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
         restart_ff <= restart_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      live_ff <= live_in;
      if (req_valid && req_ready) begin
         in_byte_ff    <= req_text_byte;
         in_present_ff <= req_byte_present;
         in_eot_ff     <= req_end_of_text;
      end
      if (consume) begin
         rsp_match_ff <= rsp_match_in;
         rsp_done_ff  <= in_eot_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_whole_match = rsp_match_ff;
   assign rsp_text_done   = rsp_done_ff;

   // Checks
   a_reset_restart: assert property (@(posedge clock) reset |=> restart_ff)
      else $error("start set not selected after reset");

   a_eot_restart: assert property (@(posedge clock) disable iff (reset)
      (consume && in_eot_ff) |=> restart_ff)
      else $error("live set not restored after end of text");

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("input beat lost while result stage stalled");

   a_live_bounded: assert property (@(posedge clock) disable iff (reset)
      !restart_ff |-> ((live_ff >> pat_len) >> 1) == '0)
      else $error("live position beyond pattern length");

endmodule

// File: tb/dot_star_pattern_matcher_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dot-star pattern matcher testbench
// Loads patterns through the register port and streams texts one byte per
// beat. A bit-set model of the live pattern positions predicts the verdict
// for every beat, and each response is checked in order against it. A short
// table of hand-picked cases comes first. Random patterns and texts follow,
// under several idle and stall mixes and one long response hold-off.
// ----------------------------------------------------------------------------
module dot_star_pattern_matcher_top_test;
   import dspm_pkg::*;

   localparam int PatMax     = PatternMaxDefault;
   localparam int NPos       = PatMax + 1;
   localparam int CycleLimit = 400000;
   localparam int HoldCycles = 150;
   localparam int PhaseBeats = 155;

   // Index with no register behind it
   localparam logic [CsrIndexW-1:0] CsrUnused = 2'd3;

   typedef struct packed {
      logic whole_match;
      logic text_done;
   } verdict_type;

   typedef enum logic {RowBeat, RowCsr} row_kind_type;

   typedef struct {
      row_kind_type         kind;
      logic [CsrIndexW-1:0] idx;
      logic [CsrDataW-1:0]  wdata;
      logic [7:0]           txt;
      logic                 present;
      logic                 eot;
      bit                   known;
      logic                 want;
   } row_type;

   // DUT ports
   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_text_byte = '0;
   logic                 req_byte_present = 1'b0;
   logic                 req_end_of_text = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_whole_match;
   logic                 rsp_text_done;
   logic                 csr_wr_en = 1'b0;
   logic [CsrIndexW-1:0] csr_index = '0;
   logic [CsrDataW-1:0]  csr_wdata = '0;

   // Matcher model state
   logic [63:0]       pat_lo = '0;
   logic [63:0]       pat_hi = '0;
   logic [4:0]        pat_len_q = '0;
   logic [PatMax:0]   live_set = NPos'(1);

   verdict_type expected_verdicts[$];
   logic [7:0]  text_buf[$];
   row_type     rows[$];

   // Run control and tallies
   int idle_pct = 0;
   int stall_pct = 0;
   bit pressure_on = 1'b0;
   bit hold_used = 1'b0;
   int hold_left = 0;
   int cycle_count = 0;
   int errors = 0;
   int beats_sent = 0;
   int rsp_checked = 0;
   int hits_seen = 0;
   int texts_sent = 0;
   int patterns_loaded = 0;

   dot_star_pattern_matcher_top #(
      .PATTERN_MAX(PatMax)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_text_byte   (req_text_byte),
      .req_byte_present(req_byte_present),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_whole_match (rsp_whole_match),
      .rsp_text_done   (rsp_text_done),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Position-set model
   // ---------------------------------------------------------------------

   // Lengths above the maximum clamp to it
   function automatic int eff_len();
      int n;
      n = int'(pat_len_q);
      return (n > PatMax) ? PatMax : n;
   endfunction

   function automatic logic [7:0] pat_at(int k);
      return (k < 8) ? pat_lo[8*k +: 8] : pat_hi[8*(k-8) +: 8];
   endfunction

   function automatic bit is_starred(int j, int n);
      return (j + 1 < n) && (pat_at(j + 1) == StarByte);
   endfunction

   // Starred positions also open the position two ahead, chained upward
   function automatic logic [PatMax:0] star_closure(logic [PatMax:0] s, int n);
      for (int j = 0; j + 2 <= n; j++)
         if (s[j] && is_starred(j, n)) s[j+2] = 1'b1;
      return s;
   endfunction

   function automatic logic [PatMax:0] start_set();
      return star_closure(NPos'(1), eff_len());
   endfunction

   function automatic logic [PatMax:0] advance_set(logic [PatMax:0] s, logic [7:0] c);
      logic [PatMax:0] nxt;
      int n;
      n = eff_len();
      nxt = '0;
      for (int j = 0; j < n; j++) begin
         if (s[j] && (pat_at(j) == c || pat_at(j) == DotByte)) begin
            if (is_starred(j, n)) nxt[j] = 1'b1;
            else nxt[j+1] = 1'b1;
         end
      end
      return star_closure(nxt, n);
   endfunction

   // Verdict is taken before an end of text restores the start set
   function automatic verdict_type step_matcher(logic [7:0] c, logic present, logic eot);
      verdict_type v;
      if (present) live_set = advance_set(live_set, c);
      v.whole_match = live_set[eff_len()];
      v.text_done = eot;
      if (eot) live_set = start_set();
      return v;
   endfunction

   // ---------------------------------------------------------------------
   // Drivers; every task is entered and left on a falling edge
   // ---------------------------------------------------------------------

   task automatic send_beat(logic [7:0] c, logic present, logic eot, bit known, logic want);
      verdict_type v;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_text_byte    <= c;
      req_byte_present <= present;
      req_end_of_text  <= eot;
      do @(posedge clock); while (!req_ready);
      v = step_matcher(c, present, eot);
      if (known) v.whole_match = want;
      expected_verdicts.push_back(v);
      beats_sent++;
      @(negedge clock);
   endtask

   // Register writes only with nothing in flight
   task automatic write_reg(logic [CsrIndexW-1:0] idx, logic [CsrDataW-1:0] data);
      bit restart;
      req_valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      restart = 1'b1;
      case (idx)
         CsrPatFirst:  pat_lo = data;
         CsrPatSecond: pat_hi = data;
         CsrPatLength: pat_len_q = data[PatLengthW-1:0];
         default:      restart = 1'b0;
      endcase
      if (restart) live_set = start_set();
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Random patterns and texts
   // ---------------------------------------------------------------------

   task automatic new_pattern();
      logic [7:0]  pb[16];
      logic [63:0] lenw;
      int r;
      int n;
      for (int k = 0; k < 16; k++) begin
         r = $urandom_range(11);
         if (k > 0 && pb[k-1] != StarByte && $urandom_range(2) == 0) pb[k] = StarByte;
         else if (r < 3) pb[k] = "a";
         else if (r < 4) pb[k] = "b";
         else if (r < 5) pb[k] = "c";
         else if (r < 8) pb[k] = DotByte;
         else if (r < 9) pb[k] = StarByte;
         else pb[k] = 8'($urandom_range(255));
      end
      r = $urandom_range(9);
      if (r < 7) n = $urandom_range(8);
      else if (r < 9) n = $urandom_range(16, 9);
      else n = $urandom_range(31, 17);
      lenw = 64'(n);
      if ($urandom_range(3) == 0) begin
         lenw = {$urandom, $urandom};
         lenw[PatLengthW-1:0] = n[PatLengthW-1:0];
      end
      write_reg(CsrPatFirst, {pb[7], pb[6], pb[5], pb[4], pb[3], pb[2], pb[1], pb[0]});
      write_reg(CsrPatSecond, {pb[15], pb[14], pb[13], pb[12], pb[11], pb[10], pb[9], pb[8]});
      write_reg(CsrPatLength, lenw);
      if ($urandom_range(5) == 0) write_reg(CsrUnused, {$urandom, $urandom});
      patterns_loaded++;
   endtask

   // Mostly texts that spell the pattern out, some of them damaged
   task automatic make_text();
      int n;
      int j;
      logic [7:0] c;
      text_buf.delete();
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(6))
            text_buf.push_back(($urandom_range(1) == 0) ? 8'($urandom_range(255))
                                                        : 8'($urandom_range(99, 97)));
      end else begin
         n = eff_len();
         j = 0;
         while (j < n) begin
            c = pat_at(j);
            if (is_starred(j, n)) begin
               repeat ($urandom_range(3))
                  text_buf.push_back((c == DotByte) ? 8'($urandom_range(255)) : c);
               j += 2;
            end else begin
               text_buf.push_back((c == DotByte) ? 8'($urandom_range(255)) : c);
               j++;
            end
         end
         if ($urandom_range(3) == 0) begin
            case ($urandom_range(2))
               0: if (text_buf.size() > 0)
                     text_buf[$urandom_range(text_buf.size() - 1)] = 8'($urandom_range(255));
               1: if (text_buf.size() > 0) void'(text_buf.pop_back());
               default: text_buf.push_back(8'($urandom_range(99, 97)));
            endcase
         end
      end
   endtask

   task automatic send_text();
      int n;
      bit tail_empty;
      n = text_buf.size();
      tail_empty = (n == 0) || ($urandom_range(7) == 0);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(19) == 0)
            send_beat(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, 1'b0);
         send_beat(text_buf[k], 1'b1, (k == n - 1) && !tail_empty, 1'b0, 1'b0);
      end
      if (tail_empty) send_beat(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, 1'b0);
      texts_sent++;
   endtask

   // ---------------------------------------------------------------------
   // Directed table helpers
   // ---------------------------------------------------------------------

   function automatic void row_beat(logic [7:0] c, logic present, logic eot,
                                    bit known = 1'b0, logic want = 1'b0);
      row_type r;
      r.kind = RowBeat;
      r.idx = '0;
      r.wdata = '0;
      r.txt = c;
      r.present = present;
      r.eot = eot;
      r.known = known;
      r.want = want;
      rows.push_back(r);
   endfunction

   function automatic void row_csr(logic [CsrIndexW-1:0] idx, logic [CsrDataW-1:0] data);
      row_type r;
      r.kind = RowCsr;
      r.idx = idx;
      r.wdata = data;
      r.txt = '0;
      r.present = 1'b0;
      r.eot = 1'b0;
      r.known = 1'b0;
      r.want = 1'b0;
      rows.push_back(r);
   endfunction

   // ---------------------------------------------------------------------
   // Response side: ready pattern, one long hold-off, checker, watchdog
   // ---------------------------------------------------------------------

   always @(negedge clock) begin
      if (pressure_on && !hold_used) begin
         hold_used <= 1'b1;
         hold_left <= HoldCycles;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin : check_rsp
      verdict_type v;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_verdicts.size() == 0) begin
            $display("%0t: response beat with nothing expected (match %0b done %0b)",
                     $time, rsp_whole_match, rsp_text_done);
            errors++;
         end else begin
            v = expected_verdicts.pop_front();
            rsp_checked++;
            if (rsp_whole_match) hits_seen++;
            if (rsp_whole_match !== v.whole_match) begin
               $display("%0t: whole_match expected %0b actual %0b",
                        $time, v.whole_match, rsp_whole_match);
               errors++;
            end
            if (rsp_text_done !== v.text_done) begin
               $display("%0t: text_done expected %0b actual %0b",
                        $time, v.text_done, rsp_text_done);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("%0t: timeout after %0d cycles, %0d beats still expected",
                  $time, cycle_count, expected_verdicts.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   initial begin
      int target;

      // Empty pattern: only the empty text matches
      row_beat(8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
      row_beat(8'hFF, 1'b0, 1'b0, 1'b1, 1'b1);
      row_beat(8'hFF, 1'b1, 1'b1, 1'b1, 1'b0);
      // a*b with junk past the length
      row_csr(CsrPatFirst, 64'hFFEE_DDCC_BB62_2A61);
      row_csr(CsrPatLength, 64'd3);
      row_beat("b", 1'b1, 1'b1);
      row_beat("a", 1'b1, 1'b0);
      row_beat("a", 1'b1, 1'b0);
      row_beat("b", 1'b1, 1'b1);
      row_beat(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
      row_beat("a", 1'b1, 1'b0);
      row_beat("c", 1'b1, 1'b1);
      // Leading star only matches a literal star
      row_csr(CsrPatFirst, 64'h2E2A);
      row_csr(CsrPatLength, 64'd2);
      row_beat("*", 1'b1, 1'b0);
      row_beat(8'h5A, 1'b1, 1'b1);
      row_beat("x", 1'b1, 1'b0);
      row_beat("y", 1'b1, 1'b1);
      // Write to the unused index must not restart the text
      row_beat("*", 1'b1, 1'b0);
      row_csr(CsrUnused, 64'hFFFF_FFFF_FFFF_FFFF);
      row_beat("q", 1'b1, 1'b1);
      // x* repeated over all 16 bytes, length field saturated
      row_csr(CsrPatFirst, 64'h2A78_2A78_2A78_2A78);
      row_csr(CsrPatSecond, 64'h2A78_2A78_2A78_2A78);
      row_csr(CsrPatLength, 64'hFFFF_FFFF_FFFF_FFFF);
      row_beat(8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
      row_beat("x", 1'b1, 1'b0);
      row_beat("x", 1'b1, 1'b1);
      row_beat(8'h00, 1'b1, 1'b1, 1'b1, 1'b0);
      // a** : second star reached as a position; a write restarts a dead text
      row_csr(CsrPatFirst, 64'h2A2A61);
      row_csr(CsrPatLength, 64'd3);
      row_beat("x", 1'b1, 1'b0);
      row_csr(CsrPatLength, 64'd3);
      row_beat("*", 1'b1, 1'b1);
      row_beat("a", 1'b1, 1'b0);
      row_beat("a", 1'b1, 1'b0);
      row_beat("*", 1'b1, 1'b1);

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         if (rows[i].kind == RowCsr) write_reg(rows[i].idx, rows[i].wdata);
         else send_beat(rows[i].txt, rows[i].present, rows[i].eot,
                        rows[i].known, rows[i].want);
      end

      // Random phases: free flow, idle sender, stalling receiver, both
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 52 : 37) : 0;
         stall_pct <= (ph == 2) ? 52 : ((ph == 3) ? 37 : 0);
         target = beats_sent + PhaseBeats;
         while (beats_sent < target) begin
            new_pattern();
            repeat ($urandom_range(8, 4)) begin
               make_text();
               send_text();
            end
         end
      end

      // Long response hold-off while the sender keeps pushing
      idle_pct = 0;
      stall_pct <= 0;
      new_pattern();
      pressure_on <= 1'b1;
      target = beats_sent + 60;
      while (beats_sent < target) begin
         make_text();
         send_text();
      end

      // Drain
      req_valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      $display("Run covered %0d patterns, %0d texts, %0d request beats", patterns_loaded,
               texts_sent, beats_sent);
      $display("Checked %0d responses, %0d of them whole matches, %0d errors", rsp_checked,
               hits_seen, errors);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
